### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: label");

`endif

### hdl/setc_pkg.sv
// Types, constants and helper functions of the swept edge tile crossing block.
`timescale 1ns / 1ps

package setc_pkg;

   localparam int TILE_SIZE  = 16;
   localparam int MAX_TILES  = 16;

   // One tile in Q.8 LSBs; a power of two, so tile division is a shift
   localparam int TILE_UNITS = TILE_SIZE * 256;
   localparam int TILE_SHIFT = $clog2(TILE_UNITS);

   localparam int POS_W   = 24;
   localparam int EXT_W   = 16;
   localparam int VEL_W   = 16;
   localparam int COORD_W = 16;
   localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_W - 1));

   // Edge coordinates: position plus displacement plus box extent
   localparam int EDGE_W = 26;
   localparam int QUO_W  = EDGE_W - TILE_SHIFT;
   localparam int REM_W  = TILE_SHIFT + 1;
   localparam int SPAN_W = 18;
   localparam int CNT_W  = $clog2(MAX_TILES + 1);

   localparam logic AXIS_VERT = 1'b1;

   typedef struct packed {
      logic                    command;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [EXT_W-1:0]        box_width;
      logic [EXT_W-1:0]        box_height;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] tile_col;
      logic signed [COORD_W-1:0] tile_row;
      logic                      last;
   } rsp_type;

   // Finished crossing test, handed from the edge pipeline to the emitter
   typedef struct packed {
      logic                      vert;
      logic [CNT_W-1:0]          count;
      logic signed [COORD_W-1:0] move_tile;
      logic signed [COORD_W-1:0] cross_tile;
      logic signed [POS_W-1:0]   across;
   } edge_item_type;

   // Tile index of a coordinate, truncating toward zero
   function automatic logic signed [QUO_W-1:0] tile_of(input logic signed [EDGE_W-1:0] v);
      logic signed [EDGE_W-1:0] biased;
      biased = v[EDGE_W-1] ? (v + EDGE_W'(TILE_UNITS - 1)) : v;
      return biased[EDGE_W-1:TILE_SHIFT];
   endfunction

   // Clamp a tile index to the result coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [QUO_W-1:0] q);
      logic signed [COORD_W-1:0] r;
      if (q > COORD_MAX) begin
         r = COORD_W'(COORD_MAX);
      end else if (q < COORD_MIN) begin
         r = COORD_W'(COORD_MIN);
      end else begin
         r = COORD_W'(q);
      end
      return r;
   endfunction

endpackage

### hdl/swept_edge_tile_crossing.sv
// Top level: edge pipeline followed by the tile run emitter.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  setc_pkg::req_type  (one box query)
//   rsp      out        rsp_valid / rsp_ready  setc_pkg::rsp_type  (one crossed tile)
//
// A query passes the stage 1, 2 and 3 registers before it reaches the output register.
// The output register emits one tile per cycle while rsp_ready is high, so a query with n tiles
// holds it for n transfers; a query with no tiles retires at stage three and never enters it.
// Reset clears the valid bits of all stages and the output register.
// A stall on rsp backs up stage by stage; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swept_edge_tile_crossing (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  setc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output setc_pkg::rsp_type rsp_data
);

   logic                    item_valid;
   logic                    item_ready;
   setc_pkg::edge_item_type item;

   setc_edge_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Emitter registers
   logic                               rsp_valid_ff;
   setc_pkg::rsp_type                  rsp_ff;
   logic [setc_pkg::CNT_W-1:0]         left_ff;
   logic signed [setc_pkg::EDGE_W-1:0] cross_ff;
   logic signed [setc_pkg::COORD_W-1:0] move_ff;
   logic                               vert_ff;

   logic load_ok, load, advance;
   logic signed [setc_pkg::COORD_W-1:0] cross_tile_in;
   setc_pkg::rsp_type                   rsp_in;

   // Take a new run when idle or when the last tile transfers
   assign load_ok    = !rsp_valid_ff || (rsp_ready && rsp_ff.last);
   assign item_ready = (item.count == '0) || load_ok;
   assign load       = load_ok && item_valid && (item.count != '0);
   assign advance    = rsp_valid_ff && rsp_ready && !rsp_ff.last;

   always_comb begin
      rsp_in = rsp_ff;
      cross_tile_in = setc_pkg::sat_coord(setc_pkg::tile_of(cross_ff));
      if (load) begin
         rsp_in.last = (item.count == setc_pkg::CNT_W'(1));
         if (item.vert) begin
            rsp_in.tile_col = item.cross_tile;
            rsp_in.tile_row = item.move_tile;
         end else begin
            rsp_in.tile_col = item.move_tile;
            rsp_in.tile_row = item.cross_tile;
         end
      end else if (advance) begin
         rsp_in.last = (left_ff == setc_pkg::CNT_W'(2));
         if (vert_ff) begin
            rsp_in.tile_col = cross_tile_in;
            rsp_in.tile_row = move_ff;
         end else begin
            rsp_in.tile_col = move_ff;
            rsp_in.tile_row = cross_tile_in;
         end
      end
   end

   // Hold, advance or reload the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         left_ff      <= item.count;
      end else if (advance) begin
         left_ff      <= left_ff - setc_pkg::CNT_W'(1);
      end else if (load_ok) begin
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end
      rsp_ff <= rsp_in;
      if (load) begin
         cross_ff <= setc_pkg::EDGE_W'(item.across) + setc_pkg::EDGE_W'(setc_pkg::TILE_UNITS);
         move_ff  <= item.move_tile;
         vert_ff  <= item.vert;
      end else if (advance) begin
         cross_ff <= cross_ff + setc_pkg::EDGE_W'(setc_pkg::TILE_UNITS);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_left_live, clock, reset, rsp_valid_ff, left_ff != '0)
   `ASSERT_IMPLY(a_last_match, clock, reset, rsp_valid_ff, rsp_ff.last == (left_ff == setc_pkg::CNT_W'(1)))
   `ASSERT_IMPLY(a_count_cap, clock, reset, item_valid, item.count <= setc_pkg::CNT_W'(setc_pkg::MAX_TILES))
   `ASSERT_NEXT(a_run_holds, clock, reset, rsp_valid_ff && rsp_ready && !rsp_ff.last, rsp_valid_ff)

endmodule

### hdl/setc_edge_pipe.sv
// Three-stage pipeline that tests the swept edge and sizes the tile run.
`timescale 1ns / 1ps

module setc_edge_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  setc_pkg::req_type      req_data,
   output logic                   item_valid,
   input  logic                   item_ready,
   output setc_pkg::edge_item_type item
);

   // Stage 1 registers: edge before and after the move
   logic                                s1_valid_ff;
   logic                                s1_vert_ff;
   logic signed [setc_pkg::EDGE_W-1:0]  s1_before_ff;
   logic signed [setc_pkg::EDGE_W-1:0]  s1_after_ff;
   logic signed [setc_pkg::POS_W-1:0]   s1_across_ff;
   logic [setc_pkg::EXT_W-1:0]          s1_edge_ff;

   // Stage 2 registers: tile indices and span
   logic                                s2_valid_ff;
   logic                                s2_vert_ff;
   logic signed [setc_pkg::QUO_W-1:0]   s2_btile_ff;
   logic signed [setc_pkg::QUO_W-1:0]   s2_atile_ff;
   logic signed [setc_pkg::SPAN_W-1:0]  s2_span_ff;
   logic signed [setc_pkg::POS_W-1:0]   s2_across_ff;
   logic signed [setc_pkg::QUO_W-1:0]   s2_ctile_ff;

   // Stage 3 register: finished item
   logic                                s3_valid_ff;
   setc_pkg::edge_item_type             s3_item_ff;

   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready  = !s3_valid_ff || item_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // Stage 1: pick the axis and the tested edge
   logic                               vert_in;
   logic signed [setc_pkg::VEL_W-1:0]  vel_in;
   logic signed [setc_pkg::POS_W-1:0]  along_in;
   logic [setc_pkg::EXT_W-1:0]         size_in;
   logic signed [setc_pkg::EXT_W:0]    off_in;
   logic signed [setc_pkg::EDGE_W-1:0] before_in;
   logic signed [setc_pkg::EDGE_W-1:0] after_in;

   always_comb begin
      vert_in  = (req_data.command == setc_pkg::AXIS_VERT);
      vel_in   = vert_in ? req_data.vel_y : req_data.vel_x;
      along_in = vert_in ? req_data.pos_y : req_data.pos_x;
      size_in  = vert_in ? req_data.box_height : req_data.box_width;
      // leading edge less one LSB when moving forward, else trailing edge plus one
      if (!vel_in[setc_pkg::VEL_W-1] && (vel_in != '0)) begin
         off_in = $signed((setc_pkg::EXT_W + 1)'(size_in) - (setc_pkg::EXT_W + 1)'(1));
      end else begin
         off_in = (setc_pkg::EXT_W + 1)'(1);
      end
      before_in = setc_pkg::EDGE_W'(along_in) + setc_pkg::EDGE_W'(off_in);
      after_in  = setc_pkg::EDGE_W'(along_in) + setc_pkg::EDGE_W'(vel_in)
                + setc_pkg::EDGE_W'(off_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready) begin
         s1_vert_ff   <= vert_in;
         s1_before_ff <= before_in;
         s1_after_ff  <= after_in;
         s1_across_ff <= vert_in ? req_data.pos_x : req_data.pos_y;
         s1_edge_ff   <= vert_in ? req_data.box_width : req_data.box_height;
      end
   end

   // Stage 2: tile indices, signed remainder of the cross coordinate, span
   logic [setc_pkg::TILE_SHIFT-1:0]    low_in;
   logic signed [setc_pkg::REM_W-1:0]  rem_in;
   logic signed [setc_pkg::SPAN_W-1:0] span_in;

   always_comb begin
      low_in = s1_across_ff[setc_pkg::TILE_SHIFT-1:0];
      // remainder takes the sign of the dividend
      if (s1_across_ff[setc_pkg::POS_W-1] && (low_in != '0)) begin
         rem_in = {1'b1, low_in};
      end else begin
         rem_in = {1'b0, low_in};
      end
      span_in = setc_pkg::SPAN_W'(s1_edge_ff) + setc_pkg::SPAN_W'(rem_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_vert_ff   <= s1_vert_ff;
         s2_btile_ff  <= setc_pkg::tile_of(s1_before_ff);
         s2_atile_ff  <= setc_pkg::tile_of(s1_after_ff);
         s2_span_ff   <= span_in;
         s2_across_ff <= s1_across_ff;
         s2_ctile_ff  <= setc_pkg::tile_of(setc_pkg::EDGE_W'(s1_across_ff));
      end
   end

   // Stage 3: crossing test and run length
   logic [setc_pkg::SPAN_W:0]                   rounded_in;
   logic [setc_pkg::SPAN_W-setc_pkg::TILE_SHIFT:0] quo_in;
   logic [setc_pkg::CNT_W-1:0]                  count_in;
   setc_pkg::edge_item_type                     item_in;

   always_comb begin
      rounded_in = (setc_pkg::SPAN_W + 1)'(s2_span_ff)
                 + (setc_pkg::SPAN_W + 1)'(setc_pkg::TILE_UNITS - 1);
      quo_in     = rounded_in[setc_pkg::SPAN_W:setc_pkg::TILE_SHIFT];
      // drop the run when the edge stays in its tile or the span is not positive
      if ((s2_btile_ff == s2_atile_ff) || s2_span_ff[setc_pkg::SPAN_W-1]
          || (s2_span_ff == '0)) begin
         count_in = '0;
      end else if (quo_in > setc_pkg::MAX_TILES) begin
         count_in = setc_pkg::CNT_W'(setc_pkg::MAX_TILES);
      end else begin
         count_in = setc_pkg::CNT_W'(quo_in);
      end
      item_in.vert       = s2_vert_ff;
      item_in.count      = count_in;
      item_in.move_tile  = setc_pkg::sat_coord(s2_atile_ff);
      item_in.cross_tile = setc_pkg::sat_coord(s2_ctile_ff);
      item_in.across     = s2_across_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         s3_item_ff <= item_in;
      end
   end

   assign item_valid = s3_valid_ff;
   assign item       = s3_item_ff;

endmodule

### verif/tb_swept_edge_tile_crossing.sv
// Self-checking testbench for the swept edge tile crossing block.
`timescale 1ns / 1ps

module tb_swept_edge_tile_crossing;

   localparam logic AXIS_HORZ = 1'b0;
   localparam int   SETTLE_CYCLES = 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   setc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   setc_pkg::rsp_type rsp_data;

   setc_pkg::req_type pending_boxes[$];
   setc_pkg::rsp_type expected_tiles[$];
   int      boxes_queued = 0;
   int      boxes_accepted = 0;
   int      mismatch_count = 0;
   int      send_idle_pct = 13;
   int      recv_idle_pct = 84;

   swept_edge_tile_crossing i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a tile index to the signed 16-bit result range
   function automatic logic signed [setc_pkg::COORD_W-1:0] clamp_tile(input longint idx);
      if (idx > setc_pkg::COORD_MAX) begin
         return setc_pkg::COORD_W'(setc_pkg::COORD_MAX);
      end
      if (idx < setc_pkg::COORD_MIN) begin
         return setc_pkg::COORD_W'(setc_pkg::COORD_MIN);
      end
      return setc_pkg::COORD_W'(idx);
   endfunction

   // Work out the tiles crossed by one box move and queue them as expected results
   function automatic void predict_crossed_tiles(input setc_pkg::req_type box);
      longint  tile_units, vel, along, across, depth, breadth;
      longint  lead_before, lead_after, rem, span, count, move_tile, cross_tile, idx;
      logic    vert;
      setc_pkg::rsp_type tile;
      tile_units = longint'(setc_pkg::TILE_UNITS);
      vert       = (box.command == setc_pkg::AXIS_VERT);
      vel        = vert ? longint'(box.vel_y) : longint'(box.vel_x);
      along      = vert ? longint'(box.pos_y) : longint'(box.pos_x);
      across     = vert ? longint'(box.pos_x) : longint'(box.pos_y);
      depth      = vert ? longint'(box.box_height) : longint'(box.box_width);
      breadth    = vert ? longint'(box.box_width) : longint'(box.box_height);
      // test the leading edge less one LSB, or the trailing edge plus one LSB
      if (vel > 0) begin
         lead_before = along + depth - 1;
      end else begin
         lead_before = along + 1;
      end
      lead_after = lead_before + vel;
      if (lead_before / tile_units == lead_after / tile_units) begin
         return;
      end
      // count tiles along the edge; remainder keeps the sign of the cross coordinate
      rem   = across % tile_units;
      span  = breadth + rem;
      count = (span > 0) ? (span + tile_units - 1) / tile_units : 0;
      if (count > setc_pkg::MAX_TILES) begin
         count = setc_pkg::MAX_TILES;
      end
      move_tile = lead_after / tile_units;
      for (idx = 0; idx < count; idx++) begin
         cross_tile = (across + idx * tile_units) / tile_units;
         if (vert) begin
            tile.tile_col = clamp_tile(cross_tile);
            tile.tile_row = clamp_tile(move_tile);
         end else begin
            tile.tile_col = clamp_tile(move_tile);
            tile.tile_row = clamp_tile(cross_tile);
         end
         tile.last = (idx == count - 1);
         expected_tiles = {expected_tiles, tile};
      end
   endfunction

   // Driver: predict on each transfer, then launch the next box or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_crossed_tiles(req_data);
            boxes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_boxes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and check each tile against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tiles.size() == 0) begin
               $error("unexpected tile transfer col %0d row %0d last %0b",
                      rsp_data.tile_col, rsp_data.tile_row, rsp_data.last);
               mismatch_count++;
            end else begin
               setc_pkg::rsp_type want;
               want = expected_tiles.pop_front();
               if (rsp_data.tile_col !== want.tile_col) begin
                  $error("tile_col expected %0d actual %0d", want.tile_col, rsp_data.tile_col);
                  mismatch_count++;
               end
               if (rsp_data.tile_row !== want.tile_row) begin
                  $error("tile_row expected %0d actual %0d", want.tile_row, rsp_data.tile_row);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0b actual %0b", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_box(input logic cmd, input int px, input int py, input int w,
                            input int h, input int vx, input int vy);
      setc_pkg::req_type box;
      box.command    = cmd;
      box.pos_x      = setc_pkg::POS_W'(px);
      box.pos_y      = setc_pkg::POS_W'(py);
      box.box_width  = setc_pkg::EXT_W'(w);
      box.box_height = setc_pkg::EXT_W'(h);
      box.vel_x      = setc_pkg::VEL_W'(vx);
      box.vel_y      = setc_pkg::VEL_W'(vy);
      pending_boxes = {pending_boxes, box};
      boxes_queued++;
   endtask

   // Random box: mostly placed near a tile line with modest sizes, the rest raw noise
   task automatic queue_random_box();
      int  tile_idx, px, py, w, h, vx, vy;
      if ($urandom_range(99) < 75) begin
         tile_idx = int'($urandom_range(4000)) - 2000;
         px = tile_idx * setc_pkg::TILE_UNITS + int'($urandom_range(8192)) - 4096;
         tile_idx = int'($urandom_range(4000)) - 2000;
         py = tile_idx * setc_pkg::TILE_UNITS + int'($urandom_range(8192)) - 4096;
         if ($urandom_range(9) == 0) begin
            w = int'($urandom_range(65535));
            h = int'($urandom_range(65535));
         end else begin
            w = int'($urandom_range(12288));
            h = int'($urandom_range(12288));
         end
         vx = int'($urandom_range(4096));
         vy = int'($urandom_range(4096));
         if ($urandom_range(1) == 1) vx = -vx;
         if ($urandom_range(1) == 1) vy = -vy;
      end else begin
         px = int'($urandom);
         py = int'($urandom);
         w  = int'($urandom);
         h  = int'($urandom);
         vx = int'($urandom);
         vy = int'($urandom);
      end
      queue_box($urandom_range(1) ? setc_pkg::AXIS_VERT : AXIS_HORZ, px, py, w, h, vx, vy);
   endtask

   task automatic wait_all_accepted();
      while (boxes_accepted != boxes_queued) @(negedge clock);
   endtask

   task automatic wait_all_tiles();
      while (expected_tiles.size() != 0) @(negedge clock);
   endtask

   // Stimulus sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: both axes, both directions, edge cases
      queue_box(AXIS_HORZ, 3840, 0, 256, 256, 512, 0);
      queue_box(AXIS_HORZ, 4196, 0, 256, 256, -512, 0);
      queue_box(AXIS_HORZ, 100, 0, 256, 256, 10, 0);
      queue_box(setc_pkg::AXIS_VERT, 4000, 3840, 12288, 256, 0, 512);
      queue_box(setc_pkg::AXIS_VERT, 0, -4000, 256, 256, 0, -512);
      queue_box(AXIS_HORZ, 4095, 0, 256, 256, 0, 0);
      queue_box(setc_pkg::AXIS_VERT, 0, 4095, 256, 256, 5000, 0);
      queue_box(AXIS_HORZ, 3840, -300, 256, 200, 512, 0);
      queue_box(AXIS_HORZ, 3840, -256, 256, 256, 512, 0);
      queue_box(AXIS_HORZ, 3840, 4095, 256, 65535, 512, 0);
      queue_box(setc_pkg::AXIS_VERT, -4095, 3840, 65535, 256, 0, 512);
      queue_box(AXIS_HORZ, -8388608, -8388608, 0, 65535, -32768, -32768);
      queue_box(AXIS_HORZ, 8388607, 8388607, 65535, 65535, 32767, 32767);
      queue_box(setc_pkg::AXIS_VERT, -8388608, -8388608, 65535, 0, -32768, -32768);
      queue_box(setc_pkg::AXIS_VERT, 8388607, 8388607, 65535, 65535, 32767, 32767);
      queue_box(AXIS_HORZ, 3840, 100, 0, 0, 512, 0);
      queue_box(AXIS_HORZ, 3840, 0, 0, 0, 512, 0);
      queue_box(AXIS_HORZ, 4000, 0, 0, 256, 200, 0);
      queue_box(AXIS_HORZ, -200, 0, 1, 256, 400, 0);
      queue_box(AXIS_HORZ, -5000, 0, 1, 256, 2000, 0);
      queue_box(AXIS_HORZ, 3840, 0, 256, 256, 1, 0);
      queue_box(setc_pkg::AXIS_VERT, -1, -1, 65535, 65535, -1, -1);
      queue_box(setc_pkg::AXIS_VERT, 0, 0, 0, 0, 0, 0);
      queue_box(AXIS_HORZ, 8384512, -8384512, 4096, 8192, -4096, 0);
      wait_all_accepted();

      // hold the sender until every tile has drained
      wait_all_tiles();

      // slow receiver
      repeat (29) queue_random_box();
      wait_all_accepted();

      // slow sender
      send_idle_pct = 84;
      recv_idle_pct = 13;
      repeat (29) queue_random_box();
      wait_all_accepted();

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (28) queue_random_box();
      wait_all_accepted();

      wait_all_tiles();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
